[rtl/bmp_pkg.sv]
// Package for the barcode module placer: field widths, color tables,
// mode codes and the sequencer state type. No dependencies.

package bmp_pkg;

   localparam int COORD_W = 8;
   localparam int CHAN_W  = 8;
   localparam int MODE_W  = 2;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_ZERO  = 2'd0;
   localparam mode_type MODE_MONO  = 2'd1;
   localparam mode_type MODE_FOUR  = 2'd2;
   localparam mode_type MODE_EIGHT = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } bgr_type;

   localparam bgr_type FOUR_TAB [4] = '{
      '{blue: 8'd0,   green: 8'd0,   red: 8'd0},
      '{blue: 8'd232, green: 8'd162, red: 8'd0},
      '{blue: 8'd23,  green: 8'd93,  red: 8'd255},
      '{blue: 8'd255, green: 8'd255, red: 8'd255}
   };

   localparam bgr_type EIGHT_TAB [8] = '{
      '{blue: 8'd10,  green: 8'd10,  red: 8'd10},
      '{blue: 8'd0,   green: 8'd0,   red: 8'd255},
      '{blue: 8'd0,   green: 8'd255, red: 8'd0},
      '{blue: 8'd0,   green: 8'd255, red: 8'd255},
      '{blue: 8'd255, green: 8'd0,   red: 8'd0},
      '{blue: 8'd255, green: 8'd0,   red: 8'd255},
      '{blue: 8'd255, green: 8'd255, red: 8'd0},
      '{blue: 8'd245, green: 8'd245, red: 8'd245}
   };

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEARCH,
      ST_HOLD
   } state_type;

   function automatic bgr_type color_of(mode_type mode, logic a, logic b, logic c);
      bgr_type res;
      case (mode)
         MODE_FOUR:  res = FOUR_TAB[{a, b}];
         MODE_EIGHT: res = EIGHT_TAB[{a, b, c}];
         default:    res = a ? '1 : '0;
      endcase
      return res;
   endfunction

endpackage

[rtl/bmp_req_if.sv]
// Input channel of the barcode module placer: one item of up to three data bits.
// Depends on nothing.

interface bmp_req_if;
   logic valid;
   logic ready;
   logic bit_a;
   logic bit_b;
   logic bit_c;

   modport source (output valid, output bit_a, output bit_b, output bit_c, input ready);
   modport sink   (input valid, input bit_a, input bit_b, input bit_c, output ready);
endinterface

[rtl/bmp_rsp_if.sv]
// Result channel of the barcode module placer: module position, color, frame flag.
// Depends on bmp_pkg for field widths.

interface bmp_rsp_if import bmp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic [CHAN_W-1:0]  blue;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  red;
   logic               last_in_frame;

   modport source (output valid, output row, output col, output blue, output green,
                   output red, output last_in_frame, input ready);
   modport sink   (input valid, input row, input col, input blue, input green,
                   input red, input last_in_frame, output ready);
endinterface

[rtl/barcode_module_placer.sv]
// Barcode module placer top level: cell cursor, free-cell search sequencer, output register.
// Depends on bmp_pkg, bmp_req_if and bmp_rsp_if.
//
//   channel | dir | handshake          | payload
//   req     | in  | req.valid/ready    | bit_a, bit_b, bit_c
//   rsp     | out | rsp.valid/ready    | row, col, blue, green, red, last_in_frame
//   csr     | in  | csr_we (no ready)  | csr_wdata = color mode
//
// Each item: accept in ST_IDLE, probes of the shared cell-compare unit in ST_SEARCH (skipped
// if no cell is free; one cell per cycle, a wrap step per row), then output register load.
// After reset the same unit finds the first free cell; req.ready is low until that scan ends.
// A stalled rsp holds the next result in ST_HOLD; req.ready is high only in ST_IDLE.

module barcode_module_placer
   import bmp_pkg::*;
#(
   parameter int GRID_HEIGHT = 64,
   parameter int GRID_WIDTH  = 64,
   parameter int EDGE_MARGIN = 4
) (
   input  logic            clock,
   input  logic            reset,
   bmp_req_if.sink         req,
   bmp_rsp_if.source       rsp,
   input  logic            csr_we,
   input  logic [MODE_W-1:0] csr_wdata
);

   localparam int PW = COORD_W + 1;
   localparam logic [PW-1:0] LO    = PW'(EDGE_MARGIN);
   localparam logic [PW-1:0] REND  = PW'(GRID_HEIGHT - EDGE_MARGIN);
   localparam logic [PW-1:0] CEND  = PW'(GRID_WIDTH - EDGE_MARGIN);
   localparam logic [PW-1:0] FIND  = PW'(EDGE_MARGIN + 8);
   localparam logic [PW-1:0] TLINE = PW'(EDGE_MARGIN + 7);
   localparam logic [PW-1:0] FC_HI = PW'(GRID_WIDTH - EDGE_MARGIN - 9);
   localparam logic [PW-1:0] FR_HI = PW'(GRID_HEIGHT - EDGE_MARGIN - 9);
   localparam logic [PW-1:0] NEAR_LO = PW'(EDGE_MARGIN + 5);
   localparam logic [PW-1:0] NEAR_HI = PW'(EDGE_MARGIN + 9);
   localparam logic [PW-1:0] CMID_LO = PW'(GRID_WIDTH / 2 - 2);
   localparam logic [PW-1:0] CMID_HI = PW'(GRID_WIDTH / 2 + 2);
   localparam logic [PW-1:0] RMID_LO = PW'(GRID_HEIGHT / 2 - 2);
   localparam logic [PW-1:0] RMID_HI = PW'(GRID_HEIGHT / 2 + 2);
   localparam logic [PW-1:0] RFAR_LO = PW'(GRID_HEIGHT - EDGE_MARGIN - 10);
   localparam logic [PW-1:0] RFAR_HI = PW'(GRID_HEIGHT - EDGE_MARGIN - 6);
   localparam logic [PW-1:0] CFAR_LO = PW'(GRID_WIDTH - EDGE_MARGIN - 10);
   localparam logic [PW-1:0] CFAR_HI = PW'(GRID_WIDTH - EDGE_MARGIN - 6);

   function automatic logic in_span(logic [PW-1:0] v, logic [PW-1:0] lo, logic [PW-1:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic reserved(logic [PW-1:0] r, logic [PW-1:0] c);
      logic finder;
      logic align;
      logic timing;
      finder = ((r <= FIND) && ((c <= FIND) || (c >= FC_HI)))
            || ((r > FIND) && (r >= FR_HI) && (c <= FIND));
      align  = (in_span(c, CMID_LO, CMID_HI) && (in_span(r, NEAR_LO, NEAR_HI)
                  || in_span(r, RMID_LO, RMID_HI) || in_span(r, RFAR_LO, RFAR_HI)))
            || (in_span(c, NEAR_LO, NEAR_HI) && in_span(r, RMID_LO, RMID_HI))
            || (in_span(c, CFAR_LO, CFAR_HI) && (in_span(r, RFAR_LO, RFAR_HI)
                  || in_span(r, RMID_LO, RMID_HI)));
      timing = (c == TLINE) || (r == TLINE);
      return finder || align || timing;
   endfunction

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [PW-1:0]      probe_row_ff, probe_row_in;
   logic [PW-1:0]      probe_col_ff, probe_col_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [COORD_W-1:0] first_row_ff, first_row_in;
   logic [COORD_W-1:0] first_col_ff, first_col_in;
   logic               any_ff, any_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [COORD_W-1:0] pend_row_ff, pend_row_in;
   logic [COORD_W-1:0] pend_col_ff, pend_col_in;
   bgr_type            pend_bgr_ff, pend_bgr_in;
   logic               pend_last_ff, pend_last_in;
   logic [COORD_W-1:0] out_row_ff, out_row_in;
   logic [COORD_W-1:0] out_col_ff, out_col_in;
   bgr_type            out_bgr_ff, out_bgr_in;
   logic               out_last_ff, out_last_in;

   logic probe_end;
   logic probe_wrap;
   logic probe_free;
   logic accept;
   logic load_out;

   assign probe_end  = probe_row_ff >= REND;
   assign probe_wrap = probe_col_ff >= CEND;
   assign probe_free = !reserved(probe_row_ff, probe_col_ff);
   assign accept     = req.valid && req.ready;
   assign load_out   = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in     = state_ff;
      mode_in      = csr_we ? csr_wdata : mode_ff;
      probe_row_in = probe_row_ff;
      probe_col_in = probe_col_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      first_row_in = first_row_ff;
      first_col_in = first_col_ff;
      any_in       = any_ff;
      pend_row_in  = pend_row_ff;
      pend_col_in  = pend_col_ff;
      pend_bgr_in  = pend_bgr_ff;
      pend_last_in = pend_last_ff;
      req.ready    = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            if (probe_end) begin
               any_in     = 1'b0;
               cur_row_in = '0;
               cur_col_in = '0;
               state_in   = ST_IDLE;
            end else if (probe_wrap) begin
               probe_row_in = probe_row_ff + PW'(1);
               probe_col_in = LO;
            end else if (probe_free) begin
               any_in       = 1'b1;
               cur_row_in   = probe_row_ff[COORD_W-1:0];
               cur_col_in   = probe_col_ff[COORD_W-1:0];
               first_row_in = probe_row_ff[COORD_W-1:0];
               first_col_in = probe_col_ff[COORD_W-1:0];
               state_in     = ST_IDLE;
            end else begin
               probe_col_in = probe_col_ff + PW'(1);
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (accept) begin
               pend_bgr_in = color_of(mode_ff, req.bit_a, req.bit_b, req.bit_c);
               if (any_ff) begin
                  pend_row_in  = cur_row_ff;
                  pend_col_in  = cur_col_ff;
                  probe_row_in = {1'b0, cur_row_ff};
                  probe_col_in = {1'b0, cur_col_ff} + PW'(1);
                  state_in     = ST_SEARCH;
               end else begin
                  pend_row_in  = '0;
                  pend_col_in  = '0;
                  pend_last_in = 1'b1;
                  state_in     = ST_HOLD;
               end
            end
         end
         ST_SEARCH: begin
            if (probe_end) begin
               cur_row_in   = first_row_ff;
               cur_col_in   = first_col_ff;
               pend_last_in = 1'b1;
               state_in     = ST_HOLD;
            end else if (probe_wrap) begin
               probe_row_in = probe_row_ff + PW'(1);
               probe_col_in = LO;
            end else if (probe_free) begin
               cur_row_in   = probe_row_ff[COORD_W-1:0];
               cur_col_in   = probe_col_ff[COORD_W-1:0];
               pend_last_in = 1'b0;
               state_in     = ST_HOLD;
            end else begin
               probe_col_in = probe_col_ff + PW'(1);
            end
         end
         ST_HOLD: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      out_row_in  = load_out ? pend_row_ff  : out_row_ff;
      out_col_in  = load_out ? pend_col_ff  : out_col_ff;
      out_bgr_in  = load_out ? pend_bgr_ff  : out_bgr_ff;
      out_last_in = load_out ? pend_last_ff : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         mode_ff      <= MODE_MONO;
         probe_row_ff <= LO;
         probe_col_ff <= LO;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         probe_row_ff <= probe_row_in;
         probe_col_ff <= probe_col_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_row_ff <= first_row_in;
      first_col_ff <= first_col_in;
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      pend_bgr_ff  <= pend_bgr_in;
      pend_last_ff <= pend_last_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_bgr_ff   <= out_bgr_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.row           = out_row_ff;
   assign rsp.col           = out_col_ff;
   assign rsp.blue          = out_bgr_ff.blue;
   assign rsp.green         = out_bgr_ff.green;
   assign rsp.red           = out_bgr_ff.red;
   assign rsp.last_in_frame = out_last_ff;

endmodule

[test/placement_checker.sv]
// Checker for the barcode module placer: watches the item, result and register ports,
// predicts each placement and compares it field by field. Depends on bmp_pkg and the
// bmp_req_if / bmp_rsp_if interfaces.

module placement_checker
   import bmp_pkg::*;
#(
   parameter int GRID_HEIGHT = 64,
   parameter int GRID_WIDTH  = 64,
   parameter int EDGE_MARGIN = 4
) (
   input  logic              clock,
   input  logic              reset,
   bmp_req_if                req,
   bmp_rsp_if                rsp,
   input  logic              csr_we,
   input  logic [MODE_W-1:0] csr_wdata,
   output int                errors,
   output int                pending
);

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      bgr_type            color;
      logic               last;
   } placement_type;

   localparam bgr_type WHITE = '{blue: 8'd255, green: 8'd255, red: 8'd255};
   localparam bgr_type BLACK = '{blue: 8'd0, green: 8'd0, red: 8'd0};

   string field_name [6] = '{"row", "col", "blue", "green", "red", "last_in_frame"};

   mode_type      mode;
   int            cur_row;
   int            cur_col;
   placement_type placements_owed [$];
   int            fault_cnt = 0;

   function automatic bit fixed_cell(int r, int c);
      int  m      = EDGE_MARGIN;
      int  h      = GRID_HEIGHT;
      int  w      = GRID_WIDTH;
      int  f      = EDGE_MARGIN + 8;
      bit  top_r  = r >= m + 5 && r <= m + 9;
      bit  mid_r  = r >= h / 2 - 2 && r <= h / 2 + 2;
      bit  low_r  = r >= h - m - 10 && r <= h - m - 6;
      bit  left_c = c >= m + 5 && c <= m + 9;
      bit  mid_c  = c >= w / 2 - 2 && c <= w / 2 + 2;
      bit  rite_c = c >= w - m - 10 && c <= w - m - 6;
      // finder corners
      if (r <= f && (c <= f || c >= w - f - 1)) return 1'b1;
      if (r > f && r >= h - f - 1 && c <= f) return 1'b1;
      // alignment squares
      if (mid_c && (top_r || mid_r || low_r)) return 1'b1;
      if (left_c && mid_r) return 1'b1;
      if (rite_c && (low_r || mid_r)) return 1'b1;
      // timing lines
      return r == m + 7 || c == m + 7;
   endfunction

   // first free cell at or after (r, c) in raster order
   function automatic bit seek_free(int r, int c, output int fr, output int fc);
      fr = 0;
      fc = 0;
      if (c < EDGE_MARGIN) c = EDGE_MARGIN;
      while (r < GRID_HEIGHT - EDGE_MARGIN) begin
         if (r >= EDGE_MARGIN) begin
            while (c < GRID_WIDTH - EDGE_MARGIN) begin
               if (!fixed_cell(r, c)) begin
                  fr = r;
                  fc = c;
                  return 1'b1;
               end
               c++;
            end
         end
         r++;
         c = EDGE_MARGIN;
      end
      return 1'b0;
   endfunction

   function automatic bgr_type shade(mode_type m, logic a, logic b, logic c);
      bgr_type v;
      case (m)
         MODE_FOUR: begin
            case ({a, b})
               2'b00:   v = BLACK;
               2'b01:   v = '{blue: 8'd232, green: 8'd162, red: 8'd0};
               2'b10:   v = '{blue: 8'd23, green: 8'd93, red: 8'd255};
               default: v = WHITE;
            endcase
         end
         MODE_EIGHT: begin
            case ({a, b, c})
               3'b000:  v = '{blue: 8'd10, green: 8'd10, red: 8'd10};
               3'b001:  v = '{blue: 8'd0, green: 8'd0, red: 8'd255};
               3'b010:  v = '{blue: 8'd0, green: 8'd255, red: 8'd0};
               3'b011:  v = '{blue: 8'd0, green: 8'd255, red: 8'd255};
               3'b100:  v = '{blue: 8'd255, green: 8'd0, red: 8'd0};
               3'b101:  v = '{blue: 8'd255, green: 8'd0, red: 8'd255};
               3'b110:  v = '{blue: 8'd255, green: 8'd255, red: 8'd0};
               default: v = '{blue: 8'd245, green: 8'd245, red: 8'd245};
            endcase
         end
         default: begin
            if (a) v = WHITE;
            else v = BLACK;
         end
      endcase
      return v;
   endfunction

   function automatic placement_type place_module(logic a, logic b, logic c);
      placement_type p;
      int            home_r, home_c, nr, nc;
      bit            any;
      any     = seek_free(EDGE_MARGIN, EDGE_MARGIN, home_r, home_c);
      p.color = shade(mode, a, b, c);
      p.last  = 1'b0;
      if (!any) begin
         p.row   = '0;
         p.col   = '0;
         p.last  = 1'b1;
         cur_row = 0;
         cur_col = 0;
      end else begin
         p.row = cur_row[COORD_W-1:0];
         p.col = cur_col[COORD_W-1:0];
         if (seek_free(cur_row, cur_col + 1, nr, nc)) begin
            cur_row = nr;
            cur_col = nc;
         end else begin
            p.last  = 1'b1;
            cur_row = home_r;
            cur_col = home_c;
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin
      placement_type    want;
      logic [7:0]       want_f [6];
      logic [7:0]       got_f [6];
      int               r0, c0;
      if (reset) begin
         placements_owed.delete();
         mode = MODE_MONO;
         if (seek_free(EDGE_MARGIN, EDGE_MARGIN, r0, c0)) begin
            cur_row = r0;
            cur_col = c0;
         end else begin
            cur_row = 0;
            cur_col = 0;
         end
      end else begin
         if (csr_we) mode = csr_wdata;
         if (req.valid && req.ready)
            placements_owed.push_back(place_module(req.bit_a, req.bit_b, req.bit_c));
         if (rsp.valid && rsp.ready) begin
            if (placements_owed.size() == 0) begin
               fault_cnt++;
               $display("%0t: unexpected item: expected none, got row %0d col %0d",
                        $time, rsp.row, rsp.col);
            end else begin
               want   = placements_owed.pop_front();
               want_f = '{want.row, want.col, want.color.blue, want.color.green,
                          want.color.red, {7'd0, want.last}};
               got_f  = '{rsp.row, rsp.col, rsp.blue, rsp.green, rsp.red,
                          {7'd0, rsp.last_in_frame}};
               for (int k = 0; k < 6; k++) begin
                  if (want_f[k] !== got_f[k]) begin
                     fault_cnt++;
                     $display("%0t: %s mismatch: expected %0d, got %0d",
                              $time, field_name[k], want_f[k], got_f[k]);
                  end
               end
            end
         end
      end
      pending <= placements_owed.size();
      errors  <= fault_cnt;
   end

endmodule

[test/testbench.sv]
// Top of the barcode module placer test: clock, reset, item and register stimulus,
// random idling on both sides, verdict. Depends on bmp_pkg, the interfaces, the
// placer RTL and placement_checker.

module testbench;
   import bmp_pkg::*;

   localparam int GRID_HEIGHT  = 64;
   localparam int GRID_WIDTH   = 64;
   localparam int EDGE_MARGIN  = 4;
   localparam int RANDOM_ITEMS = 1450;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 400;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      csr_we = 1'b0;
   mode_type  csr_wdata = MODE_MONO;
   int        errors;
   int        pending;
   bit        steady = 1'b0;
   int        sent = 0;
   int        taken = 0;
   int        cycles = 0;

   bmp_req_if req_ch ();
   bmp_rsp_if rsp_ch ();

   barcode_module_placer #(
      .GRID_HEIGHT(GRID_HEIGHT),
      .GRID_WIDTH (GRID_WIDTH),
      .EDGE_MARGIN(EDGE_MARGIN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   placement_checker #(
      .GRID_HEIGHT(GRID_HEIGHT),
      .GRID_WIDTH (GRID_WIDTH),
      .EDGE_MARGIN(EDGE_MARGIN)
   ) watch (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .errors   (errors),
      .pending  (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL barcode_module_placer");
         $finish;
      end
   end

   task automatic set_mode(mode_type m);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic offer(logic a, logic b, logic c);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.bit_a <= a;
      req_ch.bit_b <= b;
      req_ch.bit_c <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   // stop offering and wait until every placement has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic random_phase(mode_type m, int n, bit calm);
      steady <= calm;
      set_mode(m);
      repeat (n) offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
      drain();
      steady <= 1'b0;
   endtask

   // result side: random stalls, one long hold-off so the block backs up
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (taken == 300) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      bit [2:0] combo;
      req_ch.valid = 1'b0;
      req_ch.bit_a = 1'b0;
      req_ch.bit_b = 1'b0;
      req_ch.bit_c = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // mode zero behaves as black/white, unused bits ignored
      set_mode(MODE_ZERO);
      offer(1'b0, 1'b1, 1'b1);
      offer(1'b1, 1'b0, 1'b0);
      offer(1'b1, 1'b1, 1'b1);
      drain();
      set_mode(MODE_MONO);
      offer(1'b0, 1'b1, 1'b0);
      offer(1'b1, 1'b1, 1'b1);
      drain();
      set_mode(MODE_FOUR);
      for (int k = 0; k < 4; k++) begin
         combo = 3'(k);
         offer(combo[1], combo[0], ~combo[0]);
      end
      drain();
      set_mode(MODE_EIGHT);
      for (int k = 0; k < 8; k++) begin
         combo = 3'(k);
         offer(combo[2], combo[1], combo[0]);
      end
      drain();

      // random items in random modes
      while (sent < RANDOM_ITEMS)
         random_phase(mode_type'($urandom_range(0, 3)), $urandom_range(20, 120),
                      $urandom_range(0, 3) == 0);
      random_phase(MODE_EIGHT, 30, 1'b0);

      repeat (40) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("PASS barcode_module_placer");
      end else begin
         $display("FAIL barcode_module_placer");
      end
      $finish;
   end

endmodule
